// File: hw/rtl/dcb_pkg.sv
// Shared types and constants for the de Casteljau Bezier point evaluator.
package dcb_pkg;

    // Default parameter values
    localparam int MAX_DEGREE_DEF = 7;
    localparam int COORD_BITS_DEF = 16;

    // Degree register
    localparam logic [2:0] DEGREE_RESET = 3'd3;
    localparam logic [2:0] MIN_DEGREE   = 3'd2;

    // Curve parameter 1.0 in unsigned Q1.15
    localparam logic [15:0] T_ONE = 16'd32768;

    // Rounding constant for the >>15 of each lerp
    localparam int ROUND_HALF = 16384;

    // Request modes
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_EVAL = 1'b1;

    // Request transaction
    typedef struct packed {
        logic               mode;
        logic [2:0]         point_index;
        logic signed [15:0] point_x;
        logic signed [15:0] point_y;
        logic signed [15:0] point_z;
        logic [15:0]        curve_param;
    } req_item_t;

    // Response transaction
    typedef struct packed {
        logic signed [15:0] curve_x;
        logic signed [15:0] curve_y;
        logic signed [15:0] curve_z;
        logic               degree_error;
    } rsp_item_t;

endpackage

// File: hw/rtl/de_casteljau_bezier_point_top.sv
// Pipelined de Casteljau evaluator of a 3-D Bezier curve point.
// An evaluate transaction runs through the entry stage and then the triangle rows to its response.
// Throughput: one evaluate per cycle while rsp_ready is high; each triangle row is a multiply stage and an add stage.
// Load transactions write the point store and produce no response.
// Reset (rst_n low, async) empties the pipeline and sets degree to 3.
// The point store has no reset; entries are defined once loaded.
module de_casteljau_bezier_point_top
    import dcb_pkg::*;
#(
    parameter int MAX_DEGREE = MAX_DEGREE_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
)(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    input  req_item_t  req,
    output logic       rsp_valid,
    input  logic       rsp_ready,
    output rsp_item_t  rsp,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] cfg_data
);

    localparam int DEPTH = MAX_DEGREE + 1;
    localparam int IW    = $clog2(DEPTH);
    localparam int NW    = $clog2(DEPTH);
    localparam int PW    = COORD_BITS + 18;
    localparam int NSTG  = 2 * MAX_DEGREE + 1;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [PW-1:0]         prod_t;

    // Configuration
    logic [2:0] degree_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            degree_reg <= DEGREE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            degree_reg <= cfg_data;
        end
    end

    // Control point store, read in full at entry
    coord_t store_reg [3][DEPTH];

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready && req.mode == MODE_LOAD
            && int'(req.point_index) <= MAX_DEGREE)
        begin
            store_reg[0][IW'(req.point_index)] <= COORD_BITS'(req.point_x);
            store_reg[1][IW'(req.point_index)] <= COORD_BITS'(req.point_y);
            store_reg[2][IW'(req.point_index)] <= COORD_BITS'(req.point_z);
        end
    end

    // Pipeline registers
    logic          v_reg   [NSTG];
    logic [15:0]   t_reg   [NSTG];
    logic [NW-1:0] n_reg   [NSTG];
    logic          err_reg [NSTG];
    coord_t        w_reg   [NSTG][3][DEPTH];
    prod_t         p_reg   [MAX_DEGREE][3][DEPTH];

    // Per-stage ready: a stage takes new data when empty or when it drains
    logic rdy [NSTG+1];

    always_comb
    begin
        rdy[NSTG] = rsp_ready;
        for (int s = NSTG - 1; s >= 0; s--)
        begin
            rdy[s] = !v_reg[s] || rdy[s+1];
        end
    end

    assign req_ready = rdy[0];

    // Entry stage: clamp t and degree, flag a degree below the minimum, snapshot the store
    logic [15:0]   t_next;
    logic [NW-1:0] n_next;
    logic          err_next;

    always_comb
    begin
        t_next   = (req.curve_param > T_ONE) ? T_ONE : req.curve_param;
        n_next   = (int'(degree_reg) > MAX_DEGREE) ? NW'(MAX_DEGREE) : NW'(degree_reg);
        err_next = degree_reg < MIN_DEGREE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (rdy[0])
        begin
            v_reg[0] <= req_valid && req.mode == MODE_EVAL;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0] && req_valid && req.mode == MODE_EVAL)
        begin
            t_reg[0]   <= t_next;
            n_reg[0]   <= n_next;
            err_reg[0] <= err_next;
            w_reg[0]   <= store_reg;
        end
    end

    // Triangle rows: odd stage multiplies, even stage rounds and adds
    for (genvar s = 1; s < NSTG; s++)
    begin : g_stage
        localparam int ROW = (s + 1) / 2;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[s] <= 1'b0;
            end
            else if (rdy[s])
            begin
                v_reg[s] <= v_reg[s-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (rdy[s] && v_reg[s-1])
            begin
                t_reg[s]   <= t_reg[s-1];
                n_reg[s]   <= n_reg[s-1];
                err_reg[s] <= err_reg[s-1];
            end
        end

        if (s % 2 == 1)
        begin : g_mul
            // t * (b - a) for each neighbor pair
            prod_t p_next [3][DEPTH];

            always_comb
            begin
                for (int c = 0; c < 3; c++)
                begin
                    for (int k = 0; k < DEPTH; k++)
                    begin
                        if (k < MAX_DEGREE)
                        begin
                            p_next[c][k] = PW'($signed({1'b0, t_reg[s-1]}))
                                * (PW'((COORD_BITS+1)'(w_reg[s-1][c][k+1]))
                                   - PW'((COORD_BITS+1)'(w_reg[s-1][c][k])));
                        end
                        else
                        begin
                            p_next[c][k] = '0;
                        end
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                if (rdy[s] && v_reg[s-1])
                begin
                    p_reg[ROW-1] <= p_next;
                    w_reg[s]     <= w_reg[s-1];
                end
            end
        end
        else
        begin : g_add
            // a + round(p >> 15); rows past the item's degree pass through
            coord_t w_next [3][DEPTH];
            prod_t  q;
            logic   bypass;

            always_comb
            begin
                q      = '0;
                bypass = int'(n_reg[s-1]) < ROW;
                for (int c = 0; c < 3; c++)
                begin
                    for (int k = 0; k < DEPTH; k++)
                    begin
                        q = (p_reg[ROW-1][c][k] + PW'(ROUND_HALF)) >>> 15;
                        if (bypass)
                        begin
                            w_next[c][k] = w_reg[s-1][c][k];
                        end
                        else
                        begin
                            w_next[c][k] = w_reg[s-1][c][k] + q[COORD_BITS-1:0];
                        end
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                if (rdy[s] && v_reg[s-1])
                begin
                    w_reg[s] <= w_next;
                end
            end
        end
    end

    // Response from the last stage
    always_comb
    begin
        rsp_valid = v_reg[NSTG-1];
        if (err_reg[NSTG-1])
        begin
            rsp.curve_x = '0;
            rsp.curve_y = '0;
            rsp.curve_z = '0;
        end
        else
        begin
            rsp.curve_x = 16'(w_reg[NSTG-1][0][0]);
            rsp.curve_y = 16'(w_reg[NSTG-1][1][0]);
            rsp.curve_z = 16'(w_reg[NSTG-1][2][0]);
        end
        rsp.degree_error = err_reg[NSTG-1];
    end

endmodule

// File: hw/rtl/dcb_checker.sv
// Port-level checks for the Bezier point evaluator, bound to the top level.
module dcb_checker
    import dcb_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      req_valid,
    input logic      req_ready,
    input req_item_t req,
    input logic      rsp_valid,
    input logic      rsp_ready,
    input rsp_item_t rsp,
    input logic      cfg_valid,
    input logic      cfg_ready
);

    // Stalled response transaction holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    // Error responses carry the origin
    a_err_origin: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.degree_error |->
            rsp.curve_x == 16'sd0 && rsp.curve_y == 16'sd0 && rsp.curve_z == 16'sd0)
        else $error("error response not at origin");

    // A draining output never blocks requests
    a_no_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_ready |-> req_ready)
        else $error("request stalled while response side ready");

    // Config writes always taken; loads are always taken with the pipe draining
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("config write refused");

    // Request valid with stalled ready must hold the same transaction
    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_ready |=> req_valid && $stable(req.mode))
        else $error("request mode changed while stalled");

endmodule

bind de_casteljau_bezier_point_top dcb_checker u_dcb_checker (.*);
